>>> hdl/deadlock_detector_assert.svh
// assertion macros for the deadlock detector
// no dependencies; included by the top level only
`ifndef DEADLOCK_DETECTOR_ASSERT_SVH
`define DEADLOCK_DETECTOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define DD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define DD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dd_pkg.sv
// shared types, field widths and codes of the deadlock detector
// no dependencies
`default_nettype none

package dd_pkg;

    localparam int MAX_PROCS_DEF   = 16;
    localparam int MAX_RES_DEF     = 8;
    localparam int VALUE_WIDTH_DEF = 12;

    localparam int OPCODE_W   = 2;
    localparam int PIDX_W     = 4;
    localparam int RIDX_W     = 3;
    localparam int AMOUNT_W   = 12;
    localparam int MASK_W     = 16;
    localparam int PCNT_W     = 5;
    localparam int RCNT_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_ALLOC = 2'd0,
        OP_LOAD_REQ   = 2'd1,
        OP_LOAD_AVAIL = 2'd2,
        OP_RUN        = 2'd3
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_COUNT  = 2'd1;

    localparam logic [PCNT_W-1:0] PROC_COUNT_RST = 5'd16;
    localparam logic [RCNT_W-1:0] RES_COUNT_RST  = 4'd8;

    typedef struct packed {
        logic alloc_we;
        logic req_we;
        logic avail_we;
    } t_load_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_run_sts;

endpackage

`default_nettype wire

>>> hdl/dd_tables.sv
// allocation and request matrices and the available vector
// uses dd_pkg; one write port for loads, one registered read port per table
`default_nettype none

module dd_tables #(
    parameter int MAX_PROCS   = dd_pkg::MAX_PROCS_DEF,
    parameter int MAX_RES     = dd_pkg::MAX_RES_DEF,
    parameter int VALUE_WIDTH = dd_pkg::VALUE_WIDTH_DEF,
    localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
    localparam int RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1,
    localparam int DEPTH = MAX_PROCS * (2 ** RW)
) (
    input  logic                   i_clk,
    input  dd_pkg::t_load_ctl      i_ld,
    input  logic [PW-1:0]          i_ld_p,
    input  logic [RW-1:0]          i_ld_r,
    input  logic [VALUE_WIDTH-1:0] i_ld_data,
    input  logic [PW-1:0]          i_rd_p,
    input  logic [RW-1:0]          i_rd_r,
    output logic [VALUE_WIDTH-1:0] o_alloc_q,
    output logic [VALUE_WIDTH-1:0] o_req_q,
    output logic [VALUE_WIDTH-1:0] o_avail_q
);

    logic [VALUE_WIDTH-1:0] r_alloc_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_req_mem   [DEPTH];
    logic [VALUE_WIDTH-1:0] r_avail     [MAX_RES];
    logic [VALUE_WIDTH-1:0] r_alloc_q;
    logic [VALUE_WIDTH-1:0] r_req_q;
    logic [VALUE_WIDTH-1:0] r_avail_q;
    logic [PW+RW-1:0]       wr_addr;
    logic [PW+RW-1:0]       rd_addr;

    assign wr_addr = {i_ld_p, i_ld_r};
    assign rd_addr = {i_rd_p, i_rd_r};

    always_ff @(posedge i_clk) begin
        if (i_ld.alloc_we) begin
            r_alloc_mem[wr_addr] <= i_ld_data;
        end
        r_alloc_q <= r_alloc_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.req_we) begin
            r_req_mem[wr_addr] <= i_ld_data;
        end
        r_req_q <= r_req_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.avail_we) begin
            r_avail[i_ld_r] <= i_ld_data;
        end
        r_avail_q <= r_avail[i_rd_r];
    end

    assign o_alloc_q = r_alloc_q;
    assign o_req_q   = r_req_q;
    assign o_avail_q = r_avail_q;

endmodule

`default_nettype wire

>>> hdl/dd_engine.sv
// detection sequencer: walks the tables, keeps work vector and finished flags
// uses dd_pkg; reads dd_tables through one address, with the data back in the next cycle
`default_nettype none

module dd_engine #(
    parameter int MAX_PROCS   = dd_pkg::MAX_PROCS_DEF,
    parameter int MAX_RES     = dd_pkg::MAX_RES_DEF,
    parameter int VALUE_WIDTH = dd_pkg::VALUE_WIDTH_DEF,
    localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
    localparam int RW  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1,
    localparam int PCW = $clog2(MAX_PROCS + 1),
    localparam int RCW = $clog2(MAX_RES + 1),
    localparam int WW  = VALUE_WIDTH + $clog2(MAX_PROCS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [PCW-1:0]            i_np,
    input  logic [RCW-1:0]            i_nr,
    output logic [PW-1:0]             o_rd_p,
    output logic [RW-1:0]             o_rd_r,
    input  logic [VALUE_WIDTH-1:0]    i_alloc_q,
    input  logic [VALUE_WIDTH-1:0]    i_req_q,
    input  logic [VALUE_WIDTH-1:0]    i_avail_q,
    output dd_pkg::t_run_sts          o_sts,
    output logic [dd_pkg::MASK_W-1:0] o_mask,
    output logic                      o_any
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_INIT_END, S_SCAN, S_CHK, S_CHK_END, S_ADD, S_ADD_END, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        K_INIT, K_CHK, K_ADD
    } t_kind;

    t_state             r_state;
    logic [PW-1:0]      r_p;
    logic [RW-1:0]      r_r;
    logic               r_changed;
    logic               r_t_vld;
    t_kind              r_t_kind;
    logic [PW-1:0]      r_t_p;
    logic [RW-1:0]      r_t_r;
    logic               r_t_first;
    logic               r_t_last;
    logic               r_fail;
    logic               r_nz;
    logic [WW-1:0]      r_work [MAX_RES];
    logic [MAX_PROCS-1:0] r_fin;

    logic               p_last;
    logic               r_last;
    logic [WW-1:0]      work_sel;
    logic               fail_now;
    logic               nz_now;
    logic               issuing;
    t_kind              issue_kind;
    t_state             adv_state;
    logic [PW-1:0]      adv_p;
    logic               adv_changed;

    assign p_last   = (PCW'(r_p) + PCW'(1)) == i_np;
    assign r_last   = (RCW'(r_r) + RCW'(1)) == i_nr;
    assign work_sel = r_work[r_t_r];
    assign fail_now = (r_t_first ? 1'b0 : r_fail) | (WW'(i_req_q) > work_sel);
    assign nz_now   = (r_t_first ? 1'b0 : r_nz) | (i_alloc_q != '0);

    always_comb begin
        issuing    = 1'b1;
        issue_kind = K_ADD;
        unique case (r_state)
            S_INIT:  issue_kind = K_INIT;
            S_CHK:   issue_kind = K_CHK;
            S_ADD:   issue_kind = K_ADD;
            default: issuing = 1'b0;
        endcase
    end

    // move to the next process; a pass that finished somebody restarts the scan, any other pass ends the run
    always_comb begin
        if (!p_last) begin
            adv_p       = r_p + PW'(1);
            adv_state   = S_SCAN;
            adv_changed = r_changed;
        end else if (r_changed) begin
            adv_p       = '0;
            adv_state   = S_SCAN;
            adv_changed = 1'b0;
        end else begin
            adv_p       = r_p;
            adv_state   = S_DONE;
            adv_changed = r_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_p       <= '0;
            r_r       <= '0;
            r_changed <= 1'b0;
            r_t_vld   <= 1'b0;
            r_fin     <= '0;
            for (int i = 0; i < MAX_RES; i++) begin
                r_work[i] <= '0;
            end
        end else begin
            r_t_vld   <= issuing;
            r_t_kind  <= issue_kind;
            r_t_p     <= r_p;
            r_t_r     <= r_r;
            r_t_first <= (r_r == '0);
            r_t_last  <= r_last;

            // read data stage
            if (r_t_vld) begin
                unique case (r_t_kind)
                    K_INIT: begin
                        r_nz <= nz_now;
                        if (r_t_last) begin
                            r_fin[r_t_p] <= !nz_now;
                        end
                        if (r_t_p == '0) begin
                            r_work[r_t_r] <= WW'(i_avail_q);
                        end
                    end
                    K_CHK:   r_fail <= fail_now;
                    K_ADD:   r_work[r_t_r] <= work_sel + WW'(i_alloc_q);
                    default: r_fail <= r_fail;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_p <= '0;
                        r_r <= '0;
                        if (i_np == '0) begin
                            r_state <= S_DONE;
                        end else if (i_nr == '0) begin
                            // no resources in use: every row is empty
                            for (int i = 0; i < MAX_PROCS; i++) begin
                                if (i < int'(i_np)) begin
                                    r_fin[i] <= 1'b1;
                                end
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (r_last) begin
                        r_r <= '0;
                        if (p_last) begin
                            r_state <= S_INIT_END;
                        end else begin
                            r_p <= r_p + PW'(1);
                        end
                    end else begin
                        r_r <= r_r + RW'(1);
                    end
                end
                S_INIT_END: begin
                    r_p       <= '0;
                    r_changed <= 1'b0;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_fin[r_p]) begin
                        r_p       <= adv_p;
                        r_changed <= adv_changed;
                        r_state   <= adv_state;
                    end else begin
                        r_r     <= '0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_last) begin
                        r_r     <= '0;
                        r_state <= S_CHK_END;
                    end else begin
                        r_r <= r_r + RW'(1);
                    end
                end
                S_CHK_END: begin
                    if (!fail_now) begin
                        r_fin[r_p] <= 1'b1;
                        r_changed  <= 1'b1;
                        r_r        <= '0;
                        r_state    <= S_ADD;
                    end else begin
                        r_p       <= adv_p;
                        r_changed <= adv_changed;
                        r_state   <= adv_state;
                    end
                end
                S_ADD: begin
                    if (r_last) begin
                        r_r     <= '0;
                        r_state <= S_ADD_END;
                    end else begin
                        r_r <= r_r + RW'(1);
                    end
                end
                S_ADD_END: begin
                    r_p       <= adv_p;
                    r_changed <= adv_changed;
                    r_state   <= adv_state;
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_mask = '0;
        o_any  = 1'b0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            if (i < int'(i_np) && !r_fin[i]) begin
                o_any = 1'b1;
                if (i < dd_pkg::MASK_W) begin
                    o_mask[i] = 1'b1;
                end
            end
        end
    end

    assign o_rd_p     = r_p;
    assign o_rd_r     = r_r;
    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = (r_state == S_DONE);

endmodule

`default_nettype wire

>>> hdl/deadlock_detector.sv
// deadlock detector top level: handshakes, config registers, result register
// uses dd_pkg, dd_tables, dd_engine and deadlock_detector_assert.svh
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | to block  | i_in_valid / o_in_ready | opcode, process_index, resource_index, amount
//  out     | from blk  | o_out_valid / i_out_ready | deadlocked_mask, any_deadlock
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
// loads are taken back to back while no run is in progress, also while a result waits
// a run first reads every entry of the np by nr tables to set up, then each pass visits the np
// processes, checks each unfinished one over the nr resources and adds the allocation of each
// one finished, at most np + 1 passes, then the result is loaded; a zero count skips straight to that
// input is held off during a run, and a run is held off while a result waits
// reset clears control state, counts go to 16 processes and 8 resources
`default_nettype none
`include "deadlock_detector_assert.svh"

module deadlock_detector #(
    parameter int MAX_PROCS   = dd_pkg::MAX_PROCS_DEF,
    parameter int MAX_RES     = dd_pkg::MAX_RES_DEF,
    parameter int VALUE_WIDTH = dd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dd_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [dd_pkg::PIDX_W-1:0]     i_process_index,
    input  logic [dd_pkg::RIDX_W-1:0]     i_resource_index,
    input  logic [dd_pkg::AMOUNT_W-1:0]   i_amount,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dd_pkg::MASK_W-1:0]     o_deadlocked_mask,
    output logic                          o_any_deadlock,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RW  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int PCW = $clog2(MAX_PROCS + 1);
    localparam int RCW = $clog2(MAX_RES + 1);

    logic [dd_pkg::PCNT_W-1:0] r_proc_count;
    logic [dd_pkg::RCNT_W-1:0] r_res_count;
    logic                      r_out_valid;
    logic [dd_pkg::MASK_W-1:0] r_mask;
    logic                      r_any;

    dd_pkg::t_opcode           op;
    dd_pkg::t_load_ctl         ld;
    dd_pkg::t_run_sts          eng_sts;
    logic                      in_acc;
    logic                      run_acc;
    logic                      idx_ok;
    logic [PCW-1:0]            np;
    logic [RCW-1:0]            nr;
    logic [PW-1:0]             rd_p;
    logic [RW-1:0]             rd_r;
    logic [VALUE_WIDTH-1:0]    alloc_q;
    logic [VALUE_WIDTH-1:0]    req_q;
    logic [VALUE_WIDTH-1:0]    avail_q;
    logic [dd_pkg::MASK_W-1:0] eng_mask;
    logic                      eng_any;

    assign op         = dd_pkg::t_opcode'(i_opcode);
    assign o_in_ready = !eng_sts.busy && (op != dd_pkg::OP_RUN || !r_out_valid);
    assign in_acc     = i_in_valid && o_in_ready;
    assign run_acc    = in_acc && (op == dd_pkg::OP_RUN);
    assign o_cfg_ready = 1'b1;

    // loads outside the table bounds are dropped
    assign idx_ok = (32'(i_resource_index) < MAX_RES)
                    && (op == dd_pkg::OP_LOAD_AVAIL || 32'(i_process_index) < MAX_PROCS);

    assign ld.alloc_we = in_acc && idx_ok && (op == dd_pkg::OP_LOAD_ALLOC);
    assign ld.req_we   = in_acc && idx_ok && (op == dd_pkg::OP_LOAD_REQ);
    assign ld.avail_we = in_acc && idx_ok && (op == dd_pkg::OP_LOAD_AVAIL);

    // counts above the table size act as the table size
    always_comb begin
        if (32'(r_proc_count) > MAX_PROCS) begin
            np = PCW'(MAX_PROCS);
        end else begin
            np = PCW'(r_proc_count);
        end
        if (32'(r_res_count) > MAX_RES) begin
            nr = RCW'(MAX_RES);
        end else begin
            nr = RCW'(r_res_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_count <= dd_pkg::PROC_COUNT_RST;
            r_res_count  <= dd_pkg::RES_COUNT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dd_pkg::CFG_PROC_COUNT) begin
                r_proc_count <= i_cfg_data[dd_pkg::PCNT_W-1:0];
            end else if (i_cfg_index == dd_pkg::CFG_RES_COUNT) begin
                r_res_count <= i_cfg_data[dd_pkg::RCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_sts.done) begin
            r_out_valid <= 1'b1;
            r_mask      <= eng_mask;
            r_any       <= eng_any;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_deadlocked_mask = r_mask;
    assign o_any_deadlock    = r_any;

    dd_tables #(
        .MAX_PROCS   (MAX_PROCS),
        .MAX_RES     (MAX_RES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_tables (
        .i_clk     (i_clk),
        .i_ld      (ld),
        .i_ld_p    (PW'(i_process_index)),
        .i_ld_r    (RW'(i_resource_index)),
        .i_ld_data (VALUE_WIDTH'(i_amount)),
        .i_rd_p    (rd_p),
        .i_rd_r    (rd_r),
        .o_alloc_q (alloc_q),
        .o_req_q   (req_q),
        .o_avail_q (avail_q)
    );

    dd_engine #(
        .MAX_PROCS   (MAX_PROCS),
        .MAX_RES     (MAX_RES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (run_acc),
        .i_np      (np),
        .i_nr      (nr),
        .o_rd_p    (rd_p),
        .o_rd_r    (rd_r),
        .i_alloc_q (alloc_q),
        .i_req_q   (req_q),
        .i_avail_q (avail_q),
        .o_sts     (eng_sts),
        .o_mask    (eng_mask),
        .o_any     (eng_any)
    );

    `DD_ASSERT_IMPL(a_done_slot_free, i_clk, i_rst_n,
        eng_sts.done, !r_out_valid, "result while output full")
    `DD_ASSERT_NEXT(a_run_starts, i_clk, i_rst_n,
        run_acc, eng_sts.busy, "run transfer did not start engine")
    `DD_ASSERT_IMPL(a_busy_blocks_in, i_clk, i_rst_n,
        eng_sts.busy, !o_in_ready, "input taken during run")
    `DD_ASSERT_IMPL(a_any_covers_mask, i_clk, i_rst_n,
        o_out_valid && (o_deadlocked_mask != '0), o_any_deadlock, "flag clear with mask set")

endmodule

`default_nettype wire

>>> test/deadlock_detector_tb.sv
// self-checking testbench for deadlock_detector: table loads, detection runs, count registers
// depends on dd_pkg and the deadlock_detector rtl; checks every run result against its own detector
`timescale 1ns / 100ps

module deadlock_detector_tb;
    import dd_pkg::*;

    localparam int NPROC = MAX_PROCS_DEF;
    localparam int NRES  = MAX_RES_DEF;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 50;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        t_opcode             op;
        logic [PIDX_W-1:0]   pidx;
        logic [RIDX_W-1:0]   ridx;
        logic [AMOUNT_W-1:0] amount;
    } t_cmd;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              flag;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [OPCODE_W-1:0]   i_opcode = '0;
    logic [PIDX_W-1:0]     i_process_index = '0;
    logic [RIDX_W-1:0]     i_resource_index = '0;
    logic [AMOUNT_W-1:0]   i_amount = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [MASK_W-1:0]     o_deadlocked_mask;
    logic                  o_any_deadlock;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // mirror of the block's tables and count registers
    logic [AMOUNT_W-1:0] alloc_tbl [NPROC][NRES];
    logic [AMOUNT_W-1:0] req_tbl [NPROC][NRES];
    logic [AMOUNT_W-1:0] avail_tbl [NRES];
    logic [PCNT_W-1:0]   proc_cnt = PROC_COUNT_RST;
    logic [RCNT_W-1:0]   res_cnt = RES_COUNT_RST;

    // entries that some queued load will have written, tracked as stimulus is built
    bit alloc_set [NPROC][NRES];
    bit req_set [NPROC][NRES];
    bit avail_set [NRES];

    t_cmd     pending_cmds [$];
    t_verdict due_verdicts [$];
    t_cmd     offered;
    t_verdict head;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic rx_hold = 1'b0;
    int   hold_len = 0;
    event hold_start;
    int   errors = 0;
    int   phase_items = 0;

    deadlock_detector u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_process_index   (i_process_index),
        .i_resource_index  (i_resource_index),
        .i_amount          (i_amount),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_deadlocked_mask (o_deadlocked_mask),
        .o_any_deadlock    (o_any_deadlock),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // safety-sequence search over the mirrored tables
    function automatic t_verdict find_deadlocked();
        int          np;
        int          nr;
        bit          done_flag [NPROC];
        logic [16:0] work [NRES];
        bit          progress;
        bit          fits;
        t_verdict    v;
        np = (proc_cnt > NPROC) ? NPROC : int'(proc_cnt);
        nr = (res_cnt > NRES) ? NRES : int'(res_cnt);
        for (int p = 0; p < np; p++) begin
            done_flag[p] = 1'b1;
            for (int r = 0; r < nr; r++) begin
                if (alloc_tbl[p][r] != 0) done_flag[p] = 1'b0;
            end
        end
        for (int r = 0; r < nr; r++) work[r] = {5'd0, avail_tbl[r]};
        progress = 1'b1;
        while (progress) begin
            progress = 1'b0;
            for (int p = 0; p < np; p++) begin
                if (!done_flag[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < nr; r++) begin
                        if ({5'd0, req_tbl[p][r]} > work[r]) fits = 1'b0;
                    end
                    if (fits) begin
                        for (int r = 0; r < nr; r++) work[r] = work[r] + alloc_tbl[p][r];
                        done_flag[p] = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
        end
        v = '0;
        for (int p = 0; p < np; p++) begin
            if (!done_flag[p]) begin
                v.mask[p] = 1'b1;
                v.flag = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic void apply_cmd(t_cmd c);
        case (c.op)
            OP_LOAD_ALLOC: alloc_tbl[c.pidx][c.ridx] = c.amount;
            OP_LOAD_REQ:   req_tbl[c.pidx][c.ridx] = c.amount;
            OP_LOAD_AVAIL: avail_tbl[c.ridx] = c.amount;
            default:       due_verdicts.push_back(find_deadlocked());
        endcase
    endfunction

    function automatic void emit(t_opcode op, int p, int r, logic [AMOUNT_W-1:0] amt);
        t_cmd c;
        c.op = op;
        c.pidx = p[PIDX_W-1:0];
        c.ridx = r[RIDX_W-1:0];
        c.amount = amt;
        pending_cmds.push_back(c);
        case (op)
            OP_LOAD_ALLOC: alloc_set[c.pidx][c.ridx] = 1'b1;
            OP_LOAD_REQ:   req_set[c.pidx][c.ridx] = 1'b1;
            OP_LOAD_AVAIL: avail_set[c.ridx] = 1'b1;
            default:       ;
        endcase
        phase_items++;
    endfunction

    // small counts dominate so that runs end both with and without deadlock
    function automatic logic [AMOUNT_W-1:0] pick_amount(t_opcode op);
        int roll;
        int zero_pct;
        roll = $urandom_range(99);
        zero_pct = (op == OP_LOAD_ALLOC) ? 35 : (op == OP_LOAD_REQ) ? 30 : 20;
        if (roll < zero_pct) return '0;
        if (roll < 85) return AMOUNT_W'($urandom_range(1, 4));
        if (roll < 92) return '1;
        return AMOUNT_W'($urandom_range(4095));
    endfunction

    // a batch of loads with random content, then a run over the tables
    function automatic void gen_scenario();
        int      np;
        int      nr;
        int      loads;
        int      roll;
        int      p;
        int      r;
        t_opcode op;
        np = (proc_cnt > NPROC) ? NPROC : int'(proc_cnt);
        nr = (res_cnt > NRES) ? NRES : int'(res_cnt);
        if ($urandom_range(9) == 0) loads = 0;
        else if (np * nr > 32) loads = $urandom_range(8, 24);
        else loads = $urandom_range(1, 6);
        for (int k = 0; k < loads; k++) begin
            roll = $urandom_range(99);
            if (roll < 40) op = OP_LOAD_ALLOC;
            else if (roll < 80) op = OP_LOAD_REQ;
            else op = OP_LOAD_AVAIL;
            if ($urandom_range(4) != 0 && np != 0 && nr != 0) begin
                p = $urandom_range(np - 1);
                r = $urandom_range(nr - 1);
            end else begin
                p = $urandom_range(NPROC - 1);
                r = $urandom_range(NRES - 1);
            end
            emit(op, p, r, pick_amount(op));
        end
        // the run must only see entries that were loaded since reset
        for (int pp = 0; pp < np; pp++) begin
            for (int rr = 0; rr < nr; rr++) begin
                if (!alloc_set[pp][rr]) emit(OP_LOAD_ALLOC, pp, rr, pick_amount(OP_LOAD_ALLOC));
                if (!req_set[pp][rr]) emit(OP_LOAD_REQ, pp, rr, pick_amount(OP_LOAD_REQ));
            end
        end
        for (int rr = 0; rr < nr; rr++) begin
            if (!avail_set[rr]) emit(OP_LOAD_AVAIL, $urandom_range(NPROC - 1), rr,
                                     pick_amount(OP_LOAD_AVAIL));
        end
        emit(OP_RUN, $urandom_range(NPROC - 1), $urandom_range(NRES - 1),
             AMOUNT_W'($urandom_range(4095)));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PROC_COUNT) proc_cnt = data[PCNT_W-1:0];
        else if (idx == CFG_RES_COUNT) res_cnt = data[RCNT_W-1:0];
    endtask

    // wait for every queued transfer and every result, then let a trailing load finish
    task automatic settle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_in_valid || due_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] pdata, logic [CFG_DATA_W-1:0] rdata,
                             int send_pct, int recv_pct, int n_items, int hold);
        write_reg(CFG_PROC_COUNT, pdata);
        write_reg(CFG_RES_COUNT, rdata);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        if (hold != 0) begin
            hold_len = hold;
            -> hold_start;
        end
        @(negedge i_clk);
        phase_items = 0;
        while (phase_items < n_items) gen_scenario();
        settle();
    endtask

    // receiver hold-off: a result waits, the next run is held off and the input stalls
    initial begin
        forever begin
            @(hold_start);
            @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (hold_len) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_cmd(offered);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_cmds.pop_front();
                    i_opcode <= offered.op;
                    i_process_index <= offered.pidx;
                    i_resource_index <= offered.ridx;
                    i_amount <= offered.amount;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_verdicts.size() == 0) begin
                    $error("result with no run pending: mask %h flag %b",
                           o_deadlocked_mask, o_any_deadlock);
                    errors++;
                end else begin
                    head = due_verdicts.pop_front();
                    if (o_deadlocked_mask !== head.mask) begin
                        $error("deadlocked_mask: expected %h, got %h", head.mask, o_deadlocked_mask);
                        errors++;
                    end
                    if (o_any_deadlock !== head.flag) begin
                        $error("any_deadlock: expected %b, got %b", head.flag, o_any_deadlock);
                        errors++;
                    end
                end
            end
            i_out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int wait_cnt;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no processes at all, and nothing in the tables is read
        write_reg(CFG_PROC_COUNT, 8'hE0);
        write_reg(CFG_RES_COUNT, 8'hF0);
        @(negedge i_clk);
        emit(OP_RUN, 0, 0, '0);
        settle();

        // oversized process count with no resources: every process finishes
        write_reg(CFG_PROC_COUNT, 8'h1F);
        write_reg(CFG_SPARE_2, 8'hFF);
        write_reg(CFG_SPARE_3, 8'h5A);
        @(negedge i_clk);
        emit(OP_RUN, 15, 7, '1);
        settle();

        write_reg(CFG_PROC_COUNT, 8'h02);
        write_reg(CFG_RES_COUNT, 8'h01);
        @(negedge i_clk);
        // process 0 holds and wants everything, process 1 holds nothing
        emit(OP_LOAD_ALLOC, 0, 0, '1);
        emit(OP_LOAD_ALLOC, 1, 0, '0);
        emit(OP_LOAD_REQ, 0, 0, '1);
        emit(OP_LOAD_REQ, 1, 0, '0);
        emit(OP_LOAD_AVAIL, 15, 0, '0);
        emit(OP_RUN, 0, 0, '0);
        emit(OP_LOAD_AVAIL, 10, 0, '1);
        emit(OP_RUN, 0, 0, '0);
        // loads outside the counts in use are kept
        emit(OP_LOAD_ALLOC, 15, 7, 12'hAAA);
        emit(OP_LOAD_REQ, 15, 7, 12'h555);
        emit(OP_LOAD_AVAIL, 0, 7, 12'h800);
        emit(OP_RUN, 5, 3, 12'h123);
        // process 0 can only finish on a second pass, after process 1 releases
        emit(OP_LOAD_ALLOC, 0, 0, 12'd1);
        emit(OP_LOAD_REQ, 0, 0, 12'd2);
        emit(OP_LOAD_ALLOC, 1, 0, 12'd1);
        emit(OP_LOAD_REQ, 1, 0, 12'd1);
        emit(OP_LOAD_AVAIL, 7, 0, 12'd1);
        emit(OP_RUN, 0, 0, '0);
        emit(OP_LOAD_AVAIL, 3, 0, '0);
        emit(OP_RUN, 0, 0, '0);
        settle();

        run_phase(8'h03, 8'h02, 0, 0, 120, 0);
        run_phase(8'h05, 8'h04, 84, 0, 120, 0);
        run_phase(8'h02, 8'h08, 0, 84, 120, 0);
        run_phase(8'h10, 8'h01, 18, 18, 120, 0);
        run_phase(8'hFF, 8'hFF, 18, 18, 330, 0);
        run_phase(8'h01, 8'h03, 84, 0, 100, 0);
        run_phase(8'h06, 8'h03, 0, 0, 60, HOLD_CYCLES);
        run_phase(8'h04, 8'h06, 0, 84, 100, 0);
        run_phase(8'h07, 8'h02, 18, 18, 100, 0);
        run_phase(8'h10, 8'h08, 0, 0, 80, 0);

        do @(negedge i_clk); while (pending_cmds.size() != 0 || i_in_valid);
        for (wait_cnt = 0; due_verdicts.size() != 0 && wait_cnt < 200000; wait_cnt++) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_verdicts.size() != 0) begin
            $error("%0d run results never arrived", due_verdicts.size());
            errors++;
        end
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $error("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
